[src/aes128_ofb_two_channel_stream_assert.svh]
// Assertion macros for the two-channel AES-128 OFB stream block.
`ifndef AES128_OFB_TWO_CHANNEL_STREAM_ASSERT_SVH
`define AES128_OFB_TWO_CHANNEL_STREAM_ASSERT_SVH
`ifndef SYNTH
`define AOFB_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define AOFB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define AOFB_ASSERT_SAME(lbl, ante, cons)
`define AOFB_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[src/aofb_pkg.sv]
// Package with AES-128 tables, round functions and shared types.
`timescale 1ns / 1ps
`default_nettype none
package aofb_pkg;

    localparam int BLOCK_BYTES = 16;
    localparam int BLOCK_BITS  = 128;
    localparam logic [3:0] LAST_ROUND = 4'd10;

    localparam logic [1:0] REG_KEY_ONE_HIGH = 2'd0;
    localparam logic [1:0] REG_KEY_ONE_LOW  = 2'd1;
    localparam logic [1:0] REG_KEY_TWO_HIGH = 2'd2;
    localparam logic [1:0] REG_KEY_TWO_LOW  = 2'd3;

    typedef struct packed {
        logic                  avail;
        logic [BLOCK_BITS-1:0] ks;
    } ks_stat_t;

    localparam logic [7:0] SBOX_TAB [0:255] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] sbox(input logic [7:0] a);
        return SBOX_TAB[a];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] rcon(input logic [3:0] round);
        logic [7:0] r;
        case (round)
            4'd1:    r = 8'h01;
            4'd2:    r = 8'h02;
            4'd3:    r = 8'h04;
            4'd4:    r = 8'h08;
            4'd5:    r = 8'h10;
            4'd6:    r = 8'h20;
            4'd7:    r = 8'h40;
            4'd8:    r = 8'h80;
            4'd9:    r = 8'h1b;
            4'd10:   r = 8'h36;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    // Next round key from the previous one; word 0 sits in the top bits.
    function automatic logic [127:0] key_next(input logic [127:0] rk, input logic [7:0] rc);
        logic [31:0] t;
        logic [31:0] n0, n1, n2, n3;
        t  = {sbox(rk[23:16]) ^ rc, sbox(rk[15:8]), sbox(rk[7:0]), sbox(rk[31:24])};
        n0 = rk[127:96] ^ t;
        n1 = rk[95:64] ^ n0;
        n2 = rk[63:32] ^ n1;
        n3 = rk[31:0] ^ n2;
        return {n0, n1, n2, n3};
    endfunction

    // One full round; the last round leaves out the column mix.
    function automatic logic [127:0] aes_round(input logic [127:0] s, input logic [127:0] rk,
                                               input logic last);
        logic [7:0]   t [16];
        logic [7:0]   a0, a1, a2, a3, all;
        logic [127:0] r;
        int           c, rw, i;
        for (c = 0; c < 4; c++) begin
            for (rw = 0; rw < 4; rw++) begin
                t[c*4+rw] = sbox(s[127-8*((((c+rw)&3)*4)+rw) -: 8]);
            end
        end
        if (!last) begin
            for (c = 0; c < 4; c++) begin
                a0  = t[c*4];
                a1  = t[c*4+1];
                a2  = t[c*4+2];
                a3  = t[c*4+3];
                all = a0 ^ a1 ^ a2 ^ a3;
                t[c*4]   = a0 ^ all ^ xtime(a0 ^ a1);
                t[c*4+1] = a1 ^ all ^ xtime(a1 ^ a2);
                t[c*4+2] = a2 ^ all ^ xtime(a2 ^ a3);
                t[c*4+3] = a3 ^ all ^ xtime(a3 ^ a0);
            end
        end
        for (i = 0; i < 16; i++) begin
            r[127-8*i -: 8] = t[i] ^ rk[127-8*i -: 8];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

[src/aofb_lane.sv]
// One channel lane: iterative AES-128 keystream generator with a two-entry buffer.
`timescale 1ns / 1ps
`default_nettype none
module aofb_lane (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic [127:0]   key,
    input  wire logic           clear,
    input  wire logic           pop,
    output aofb_pkg::ks_stat_t  stat
);

    logic [127:0] fb_reg, fb_next;
    logic [127:0] st_reg, st_next;
    logic [127:0] rk_reg, rk_next;
    logic [3:0]   round_reg, round_next;
    logic         busy_reg, busy_next;
    logic [127:0] q_reg [2];
    logic [127:0] q_next [2];
    logic [1:0]   cnt_reg, cnt_next;
    logic [127:0] rk_round;
    logic [127:0] st_round;
    logic         push;
    logic         pop_ok;
    logic [1:0]   cnt_mid;

    assign rk_round = aofb_pkg::key_next(rk_reg, aofb_pkg::rcon(round_reg));
    assign st_round = aofb_pkg::aes_round(st_reg, rk_round, round_reg == aofb_pkg::LAST_ROUND);
    assign push     = busy_reg && (round_reg == aofb_pkg::LAST_ROUND);
    assign pop_ok   = pop && (cnt_reg != 2'd0);
    assign cnt_mid  = cnt_reg - {1'b0, pop_ok};

    always_comb begin
        fb_next    = fb_reg;
        st_next    = st_reg;
        rk_next    = rk_reg;
        round_next = round_reg;
        busy_next  = busy_reg;
        q_next     = q_reg;
        cnt_next   = cnt_reg;
        if (clear) begin
            fb_next   = '0;
            busy_next = 1'b0;
            cnt_next  = 2'd0;
        end else begin
            if (busy_reg) begin
                st_next    = st_round;
                rk_next    = rk_round;
                round_next = round_reg + 4'd1;
                if (push) begin
                    busy_next = 1'b0;
                    fb_next   = st_round;
                end
            end else if (cnt_reg != 2'd2) begin
                st_next    = fb_reg ^ key;
                rk_next    = key;
                round_next = 4'd1;
                busy_next  = 1'b1;
            end
            if (pop_ok) begin
                q_next[0] = q_reg[1];
            end
            if (push) begin
                q_next[cnt_mid[0]] = st_round;
            end
            cnt_next = cnt_mid + {1'b0, push};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fb_reg   <= '0;
            busy_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end else begin
            fb_reg   <= fb_next;
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        st_reg    <= st_next;
        rk_reg    <= rk_next;
        round_reg <= round_next;
        q_reg     <= q_next;
    end

    assign stat.avail = (cnt_reg != 2'd0);
    assign stat.ks    = q_reg[0];

endmodule
`default_nettype wire

[src/aofb_merge.sv]
// Merging stage: picks the channel keystream, XORs, masks and registers the result.
`timescale 1ns / 1ps
`default_nettype none
module aofb_merge (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           load,
    input  wire logic           channel,
    input  wire logic [63:0]    data_high,
    input  wire logic [63:0]    data_low,
    input  wire logic [4:0]     byte_count,
    input  aofb_pkg::ks_stat_t  stat_one,
    input  aofb_pkg::ks_stat_t  stat_two,
    output logic                out_free,
    output logic                m_valid,
    input  wire logic           m_ready,
    output logic [63:0]         m_result_high,
    output logic [63:0]         m_result_low,
    output logic [4:0]          m_result_count
);

    logic         m_valid_reg, m_valid_next;
    logic [127:0] res_reg;
    logic [4:0]   count_reg;
    logic [4:0]   count_sat;
    logic [127:0] ks;
    logic [127:0] mask;
    logic [127:0] res;

    assign count_sat = (byte_count > 5'd16) ? 5'd16 : byte_count;
    assign ks        = channel ? stat_two.ks : stat_one.ks;

    always_comb begin
        for (int i = 0; i < aofb_pkg::BLOCK_BYTES; i++) begin
            mask[127-8*i -: 8] = ({1'b0, 4'(i)} < count_sat) ? 8'hff : 8'h00;
        end
    end

    assign res          = ({data_high, data_low} ^ ks) & mask;
    assign out_free     = !m_valid_reg || m_ready;
    assign m_valid_next = load || (m_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        if (load) begin
            res_reg   <= res;
            count_reg <= count_sat;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_result_high  = res_reg[127:64];
    assign m_result_low   = res_reg[63:0];
    assign m_result_count = count_reg;

endmodule
`default_nettype wire

[src/aes128_ofb_two_channel_stream.sv]
// Top level of the two-channel AES-128 OFB stream block.
// An accepted transaction reaches the registered result in the next cycle.
// Throughput: one transaction per cycle while the output register is free and the chosen
// channel has keystream buffered; a lane refills a block by a load step and ten AES rounds.
// Reset clears keys and both feedback values; each lane then computes its first block.
// A key write restarts both lanes from a zero feedback value in the same way.
`timescale 1ns / 1ps
`default_nettype none
`include "aes128_ofb_two_channel_stream_assert.svh"
module aes128_ofb_two_channel_stream (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [63:0] cfg_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_channel,
    input  wire logic [63:0] s_data_high,
    input  wire logic [63:0] s_data_low,
    input  wire logic [4:0]  s_byte_count,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [63:0]      m_result_high,
    output logic [63:0]      m_result_low,
    output logic [4:0]       m_result_count
);

    // Key registers as written through the configuration port.
    logic [63:0] key_one_high_reg, key_one_high_next;
    logic [63:0] key_one_low_reg, key_one_low_next;
    logic [63:0] key_two_high_reg, key_two_high_next;
    logic [63:0] key_two_low_reg, key_two_low_next;

    aofb_pkg::ks_stat_t stat_one;
    aofb_pkg::ks_stat_t stat_two;
    logic               out_free;
    logic               ks_ok;
    logic               accept;
    logic               count_zero;
    logic               pop_one;
    logic               pop_two;

    always_comb begin
        key_one_high_next = key_one_high_reg;
        key_one_low_next  = key_one_low_reg;
        key_two_high_next = key_two_high_reg;
        key_two_low_next  = key_two_low_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                aofb_pkg::REG_KEY_ONE_HIGH: key_one_high_next = cfg_data;
                aofb_pkg::REG_KEY_ONE_LOW:  key_one_low_next  = cfg_data;
                aofb_pkg::REG_KEY_TWO_HIGH: key_two_high_next = cfg_data;
                aofb_pkg::REG_KEY_TWO_LOW:  key_two_low_next  = cfg_data;
                default:                    key_one_high_next = key_one_high_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_one_high_reg <= '0;
            key_one_low_reg  <= '0;
            key_two_high_reg <= '0;
            key_two_low_reg  <= '0;
        end else begin
            key_one_high_reg <= key_one_high_next;
            key_one_low_reg  <= key_one_low_next;
            key_two_high_reg <= key_two_high_next;
            key_two_low_reg  <= key_two_low_next;
        end
    end

    // A transaction with a zero byte count needs no keystream and consumes none.
    // Any other one takes the head block of its channel's lane, so the lane must
    // have a block ready. The output register frees up as the result is taken.
    assign count_zero = (s_byte_count == 5'd0);
    assign ks_ok      = count_zero || (s_channel ? stat_two.avail : stat_one.avail);
    assign s_ready    = out_free && ks_ok;
    assign accept     = s_valid && s_ready;
    assign pop_one    = accept && !count_zero && !s_channel;
    assign pop_two    = accept && !count_zero && s_channel;

    // Every key write discards buffered keystream and resets both feedback values.
    aofb_lane u_lane_one (
        .aclk    (aclk),
        .aresetn (aresetn),
        .key     ({key_one_high_reg, key_one_low_reg}),
        .clear   (cfg_we),
        .pop     (pop_one),
        .stat    (stat_one)
    );

    aofb_lane u_lane_two (
        .aclk    (aclk),
        .aresetn (aresetn),
        .key     ({key_two_high_reg, key_two_low_reg}),
        .clear   (cfg_we),
        .pop     (pop_two),
        .stat    (stat_two)
    );

    aofb_merge u_merge (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .load           (accept),
        .channel        (s_channel),
        .data_high      (s_data_high),
        .data_low       (s_data_low),
        .byte_count     (s_byte_count),
        .stat_one       (stat_one),
        .stat_two       (stat_two),
        .out_free       (out_free),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_high  (m_result_high),
        .m_result_low   (m_result_low),
        .m_result_count (m_result_count)
    );

    // A key write leaves neither lane with stale keystream.
    `AOFB_ASSERT_NEXT(a_key_flush, cfg_we, !stat_one.avail && !stat_two.avail)
    // A result taken with nothing new behind it empties the output register.
    `AOFB_ASSERT_NEXT(a_out_drain, m_valid && m_ready && !accept, !m_valid)
    // An accepted transaction always shows up as a valid result next cycle.
    `AOFB_ASSERT_NEXT(a_out_load, accept, m_valid)
    // A result never shows more bytes than one block holds.
    `AOFB_ASSERT_SAME(a_count_range, m_valid, m_result_count <= 5'd16)

endmodule
`default_nettype wire
